// ===== hdl/uofp_pkg.sv =====
// ----------------------------------------------------------------------------
// uofp_pkg
// Types, codes and character helpers for the origin-form URI parser.
// ----------------------------------------------------------------------------
package uofp_pkg;

   localparam int CountWidth = 13;
   localparam logic [CountWidth-1:0] CountMax = 13'd8191;
   localparam logic [CountWidth-1:0] MaxLengthReset = 13'd8190;

   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;

   // parse phase codes
   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_PATH  = 3'd1;
   localparam logic [2:0] PH_QUERY = 3'd2;
   localparam logic [2:0] PH_PCT1  = 3'd3;
   localparam logic [2:0] PH_PCT2  = 3'd4;
   localparam logic [2:0] PH_HASH  = 3'd5;

   // sticky error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_BAD  = 2'd2;
   localparam logic [1:0] ERR_LONG = 2'd3;

   // status codes
   localparam logic [1:0] ST_CONT   = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;
   localparam logic [1:0] ST_LONG   = 2'd3;

   // delimiter characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_QUEST   = 8'h3f;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_SLASH   = 8'h2f;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       in_query;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]            phase;
      logic                  query_part;
      logic                  last_slash;
      logic [3:0]            first_hex;
      logic [CountWidth-1:0] byte_count;
      logic [1:0]            sticky_error;
   } state_type;

   localparam state_type StateReset = '{
      phase: PH_START, query_part: 1'b0, last_slash: 1'b0, first_hex: 4'd0,
      byte_count: '0, sticky_error: ERR_NONE};

   function automatic logic is_pchar(input logic [7:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                       8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h21, 8'h24, 8'h26, 8'h27,
                       8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h3a,
                       8'h40};
   endfunction

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b0, c[3:0]};
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

// ===== hdl/uofp_csr.sv =====
// ----------------------------------------------------------------------------
// uofp_csr
// Register port holding the max_length limit.
// ----------------------------------------------------------------------------
module uofp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [uofp_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [uofp_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [uofp_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                  pready,
   output logic [uofp_pkg::CountWidth-1:0]       max_length
);

   logic [uofp_pkg::CountWidth-1:0] max_length_ff;
   logic [uofp_pkg::CountWidth-1:0] max_length_in;
   logic                            sel_max;

   assign sel_max = (paddr[uofp_pkg::CsrAddrWidth-1] == 1'b0);
   assign pready  = 1'b1;

   always_comb begin
      max_length_in = max_length_ff;
      if (psel && penable && pwrite && sel_max) begin
         max_length_in = pwdata[uofp_pkg::CountWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= uofp_pkg::MaxLengthReset;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_max) begin
         prdata[uofp_pkg::CountWidth-1:0] = max_length_ff;
      end
   end

   assign max_length = max_length_ff;

endmodule

// ===== hdl/uofp_step.sv =====
// ----------------------------------------------------------------------------
// uofp_step
// Next-state and result logic for one URI byte or end request.
// ----------------------------------------------------------------------------
module uofp_step (
   input  uofp_pkg::state_type             state,
   input  uofp_pkg::req_type               req,
   input  logic [uofp_pkg::CountWidth-1:0] max_length,
   output uofp_pkg::state_type             state_next,
   output uofp_pkg::rsp_type               rsp
);

   logic [uofp_pkg::CountWidth-1:0] count_inc;
   logic [4:0]                      hv;
   logic [7:0]                      data_byte;
   logic                            emit;
   logic                            bad;
   logic [1:0]                      err;

   assign hv = uofp_pkg::hex_value(req.ch);

   always_comb begin
      state_next = state;
      rsp        = '0;
      emit       = 1'b0;
      bad        = 1'b0;
      data_byte  = req.ch;
      err        = state.sticky_error;
      count_inc  = (state.byte_count == uofp_pkg::CountMax) ? state.byte_count
                   : state.byte_count + 1'b1;

      if (req.end_mark) begin
         if (state.sticky_error == uofp_pkg::ERR_LONG) begin
            rsp.status = uofp_pkg::ST_LONG;
         end else if (state.sticky_error != uofp_pkg::ERR_NONE ||
                      state.phase == uofp_pkg::PH_START ||
                      state.phase == uofp_pkg::PH_PCT1 ||
                      state.phase == uofp_pkg::PH_PCT2) begin
            rsp.status = uofp_pkg::ST_BAD;
         end else begin
            rsp.status = uofp_pkg::ST_ACCEPT;
         end
         state_next = uofp_pkg::StateReset;
      end else begin
         state_next.byte_count = count_inc;
         if (count_inc > max_length) begin
            err = uofp_pkg::ERR_LONG;
         end
         if (err == uofp_pkg::ERR_NONE) begin
            if (req.ch == uofp_pkg::CH_NUL) begin
               bad = 1'b1;
            end else begin
               case (state.phase)
                  uofp_pkg::PH_START: begin
                     if (req.ch == uofp_pkg::CH_SLASH) begin
                        state_next.phase = uofp_pkg::PH_PATH;
                        emit = 1'b1;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  uofp_pkg::PH_PATH: begin
                     if (req.ch == uofp_pkg::CH_PERCENT) begin
                        state_next.phase = uofp_pkg::PH_PCT1;
                     end else if (req.ch == uofp_pkg::CH_QUEST) begin
                        state_next.phase = uofp_pkg::PH_QUERY;
                        state_next.query_part = 1'b1;
                     end else if (req.ch == uofp_pkg::CH_SLASH) begin
                        if (state.last_slash) begin
                           bad = 1'b1;
                        end else begin
                           emit = 1'b1;
                        end
                     end else if (uofp_pkg::is_pchar(req.ch)) begin
                        emit = 1'b1;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  uofp_pkg::PH_QUERY: begin
                     if (req.ch == uofp_pkg::CH_HASH) begin
                        state_next.phase = uofp_pkg::PH_HASH;
                     end else if (req.ch == uofp_pkg::CH_PERCENT) begin
                        state_next.phase = uofp_pkg::PH_PCT1;
                     end else if (req.ch == uofp_pkg::CH_SLASH ||
                                  req.ch == uofp_pkg::CH_QUEST ||
                                  uofp_pkg::is_pchar(req.ch)) begin
                        emit = 1'b1;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  uofp_pkg::PH_PCT1: begin
                     if (!hv[4]) begin
                        state_next.first_hex = hv[3:0];
                        state_next.phase = uofp_pkg::PH_PCT2;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  uofp_pkg::PH_PCT2: begin
                     if (!hv[4]) begin
                        data_byte = {state.first_hex, hv[3:0]};
                        emit = 1'b1;
                        state_next.phase = state.query_part ? uofp_pkg::PH_QUERY
                                           : uofp_pkg::PH_PATH;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  default: begin
                     bad = 1'b1;
                  end
               endcase
            end
            if (bad) begin
               err  = uofp_pkg::ERR_BAD;
               emit = 1'b0;
               state_next.phase = state.phase;
               state_next.query_part = state.query_part;
               state_next.first_hex = state.first_hex;
            end
            if (emit) begin
               rsp.byte_valid = 1'b1;
               rsp.out_byte   = data_byte;
               rsp.in_query   = state.query_part;
               if (!state.query_part) begin
                  state_next.last_slash = (data_byte == uofp_pkg::CH_SLASH);
               end
            end
         end
         state_next.sticky_error = err;
         rsp.status = err;
      end
   end

endmodule

// ===== hdl/uri_origin_form_parser_unit.sv =====
// ----------------------------------------------------------------------------
// uri_origin_form_parser_unit
// Origin-form URI checker and percent-decoder, one byte per request.
// ----------------------------------------------------------------------------
// path: request held in the input register, then parser logic into the result
//   register once the result side is free (result empty or rsp_ready)
// throughput: one request per cycle unless stalled; single parser state update
// reset: parser state cleared to the start phase, max_length set to 8190
// ----------------------------------------------------------------------------
module uri_origin_form_parser_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  uofp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output uofp_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [uofp_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [uofp_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [uofp_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                  pready
);

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   uofp_pkg::req_type               s1_req_ff;
   uofp_pkg::state_type             state_ff;
   uofp_pkg::state_type             state_in;
   uofp_pkg::state_type             state_next;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   uofp_pkg::rsp_type               rsp_ff;
   uofp_pkg::rsp_type               rsp_next;
   logic [uofp_pkg::CountWidth-1:0] max_length;
   logic                            advance;

   uofp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .max_length (max_length)
   );

   uofp_step u_step (
      .state      (state_ff),
      .req        (s1_req_ff),
      .max_length (max_length),
      .state_next (state_next),
      .rsp        (rsp_next)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      state_in = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= uofp_pkg::StateReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the origin-form URI parser. Requests carry URI bytes
// and end marks; a local parser model predicts every result, which is checked
// in order, field by field. Covers directed corner cases, length limits across
// several max_length settings, random URIs and noise, with random stalls on
// both channels while idle_on is set.
// ----------------------------------------------------------------------------
module testbench;
   import uofp_pkg::*;

   localparam logic [CsrAddrWidth-1:0] REG_MAX_LENGTH = '0;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // parser model state
   logic [2:0]            uri_phase;
   logic                  uri_in_query;
   logic [7:0]            uri_last_byte;
   logic [3:0]            uri_first_hex;
   logic [CountWidth-1:0] uri_count;
   logic [1:0]            uri_error;
   logic [CountWidth-1:0] max_length_cfg;

   rsp_type parse_results_due[$];
   int      mismatch_count;
   int      requests_sent;
   bit      idle_on;

   uri_origin_form_parser_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic uri_pchar(input logic [7:0] c);
      if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
          (c >= 8'h30 && c <= 8'h39)) begin
         return 1'b1;
      end
      case (c)
         8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
         8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h3a, 8'h40: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
      return 5'h10;
   endfunction

   function automatic void clear_uri();
      uri_phase     = PH_START;
      uri_in_query  = 1'b0;
      uri_last_byte = 8'h00;
      uri_first_hex = 4'h0;
      uri_count     = '0;
      uri_error     = ERR_NONE;
   endfunction

   function automatic rsp_type parse_uri_byte(input req_type r);
      rsp_type    res;
      logic [7:0] c;
      logic [4:0] hv;
      logic       bad;
      res = '0;
      c   = r.ch;
      bad = 1'b0;
      if (r.end_mark) begin
         if (uri_error == ERR_LONG) begin
            res.status = ST_LONG;
         end else if (uri_error != ERR_NONE || uri_phase == PH_START ||
                      uri_phase == PH_PCT1 || uri_phase == PH_PCT2) begin
            res.status = ST_BAD;
         end else begin
            res.status = ST_ACCEPT;
         end
         clear_uri();
         return res;
      end
      if (uri_count != CountMax) uri_count = uri_count + 1'b1;
      if (uri_count > max_length_cfg) uri_error = ERR_LONG;
      if (uri_error == ERR_NONE) begin
         hv = hex_digit(c);
         if (c == CH_NUL) begin
            bad = 1'b1;
         end else begin
            case (uri_phase)
               PH_START: begin
                  if (c == CH_SLASH) begin
                     uri_phase = PH_PATH;
                     res.byte_valid = 1'b1;
                  end else bad = 1'b1;
               end
               PH_PATH: begin
                  if (c == CH_PERCENT) begin
                     uri_phase = PH_PCT1;
                  end else if (c == CH_QUEST) begin
                     uri_phase = PH_QUERY;
                     uri_in_query = 1'b1;
                  end else if (c == CH_SLASH) begin
                     if (uri_last_byte == CH_SLASH) bad = 1'b1;
                     else res.byte_valid = 1'b1;
                  end else if (uri_pchar(c)) begin
                     res.byte_valid = 1'b1;
                  end else bad = 1'b1;
               end
               PH_QUERY: begin
                  if (c == CH_HASH) begin
                     uri_phase = PH_HASH;
                  end else if (c == CH_PERCENT) begin
                     uri_phase = PH_PCT1;
                  end else if (c == CH_SLASH || c == CH_QUEST || uri_pchar(c)) begin
                     res.byte_valid = 1'b1;
                  end else bad = 1'b1;
               end
               PH_PCT1: begin
                  if (!hv[4]) begin
                     uri_first_hex = hv[3:0];
                     uri_phase = PH_PCT2;
                  end else bad = 1'b1;
               end
               PH_PCT2: begin
                  if (!hv[4]) begin
                     c = {uri_first_hex, hv[3:0]};
                     res.byte_valid = 1'b1;
                     uri_phase = uri_in_query ? PH_QUERY : PH_PATH;
                  end else bad = 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
         if (bad) begin
            uri_error = ERR_BAD;
            res.byte_valid = 1'b0;
         end
         if (res.byte_valid) begin
            res.out_byte = c;
            res.in_query = uri_in_query;
            if (!uri_in_query) uri_last_byte = c;
         end
      end
      res.status = uri_error;
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parse_results_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result valid=%0d byte=%02h query=%0d status=%0d",
               rsp_data.byte_valid, rsp_data.out_byte, rsp_data.in_query, rsp_data.status));
         end else begin
            want = parse_results_due.pop_front();
            if (rsp_data.byte_valid !== want.byte_valid || rsp_data.out_byte !== want.out_byte ||
                rsp_data.in_query !== want.in_query || rsp_data.status !== want.status) begin
               note_mismatch($sformatf(
                  "expected valid=%0d byte=%02h query=%0d status=%0d, got %0d %02h %0d %0d",
                  want.byte_valid, want.out_byte, want.in_query, want.status,
                  rsp_data.byte_valid, rsp_data.out_byte, rsp_data.in_query,
                  rsp_data.status));
            end
         end
      end
   end

   // result side stalls
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [7:0] ch, input logic end_mark);
      req_type r;
      r.ch = ch;
      r.end_mark = end_mark;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_results_due.push_back(parse_uri_byte(r));
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_max_length();
      logic [CsrDataWidth-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= REG_MAX_LENGTH;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[CountWidth-1:0] !== max_length_cfg) begin
         note_mismatch($sformatf("max_length read expected %0d, got %0d",
            max_length_cfg, got[CountWidth-1:0]));
      end
   endtask

   task automatic write_max_length(input int unsigned value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= REG_MAX_LENGTH;
      pwdata  <= CsrDataWidth'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      max_length_cfg = value[CountWidth-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_max_length();
   endtask

   function automatic logic [7:0] hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
   endfunction

   function automatic logic [7:0] random_pchar();
      logic [7:0] c;
      c = 8'(CH_SLASH);
      while (!uri_pchar(c)) c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic send_random_uri();
      int unsigned kind;
      int unsigned len;
      logic        in_q;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         len = $urandom_range(0, 8);
         repeat (len) send_request(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_request(CH_SLASH, 1'b0);
         in_q = 1'b0;
         len = $urandom_range(0, 14);
         repeat (len) begin
            case ($urandom_range(0, 11))
               0: send_request(CH_SLASH, 1'b0);
               1, 2: begin
                  send_request(CH_PERCENT, 1'b0);
                  send_request(hex_char(), 1'b0);
                  send_request(hex_char(), 1'b0);
               end
               3: begin
                  send_request(CH_QUEST, 1'b0);
                  in_q = 1'b1;
               end
               4: begin
                  case ($urandom_range(0, 3))
                     0: send_request(CH_HASH, 1'b0);
                     1: send_request(CH_NUL, 1'b0);
                     default: send_request(8'($urandom_range(0, 255)), 1'b0);
                  endcase
               end
               default: send_request(random_pchar(), 1'b0);
            endcase
         end
         if (kind == 2) begin
            // cut off inside an escape
            send_request(CH_PERCENT, 1'b0);
            if ($urandom_range(0, 1)) send_request(hex_char(), 1'b0);
         end else if (in_q && $urandom_range(0, 2) == 0) begin
            send_request(CH_HASH, 1'b0);
            if ($urandom_range(0, 3) == 0) send_request(random_pchar(), 1'b0);
         end
      end
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_reset_value();
      check_max_length();
   endtask

   task automatic test_directed_uris();
      send_request(8'hff, 1'b1);
      send_text("/%00?%3f#");
      send_request(8'h00, 1'b1);
      send_text("/#");
      send_request(8'h00, 1'b1);
      send_text("/%2F/");
      send_request(8'h00, 1'b1);
      send_text("/");
      send_request(CH_NUL, 1'b0);
      send_request(8'h00, 1'b1);
      send_text("/%4");
      send_request(8'h00, 1'b1);
      send_text("/?#a");
      send_request(8'hff, 1'b1);
   endtask

   task automatic test_length_limits();
      write_max_length(0);
      send_text("/a");
      send_request(8'h00, 1'b1);
      write_max_length(1);
      send_text("/");
      send_request(8'h00, 1'b1);
      write_max_length(2);
      send_text("xyz");
      send_request(8'h00, 1'b1);
      write_max_length(CountMax);
      send_text("/ok?q=1");
      send_request(8'h00, 1'b1);
   endtask

   task automatic test_random_uris();
      int unsigned phase;
      int unsigned limit;
      int unsigned pause_at;
      phase = 0;
      while (requests_sent < 1150) begin
         case (phase % 6)
            0: limit = 0;
            1: limit = CountMax;
            2: limit = $urandom_range(1, 24);
            3: limit = MaxLengthReset;
            4: limit = $urandom_range(0, CountMax);
            default: limit = $urandom_range(2, 12);
         endcase
         write_max_length(limit);
         idle_on = (phase % 3 != 2);
         pause_at = $urandom_range(0, 14);
         for (int i = 0; i < 15; i++) begin
            if (i == pause_at) wait_drained();
            send_random_uri();
         end
         phase++;
      end
   endtask

   task automatic test_quiet_tail();
      write_max_length(MaxLengthReset);
      idle_on = 1'b0;
      while (requests_sent < 1550) send_random_uri();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      idle_on   = 1'b1;
      mismatch_count = 0;
      requests_sent  = 0;
      max_length_cfg = MaxLengthReset;
      clear_uri();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_value();
      test_directed_uris();
      test_length_limits();
      test_random_uris();
      test_quiet_tail();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && parse_results_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
